@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, pre, post, msg) \
    `ASSERT_CLK(lbl, (pre) |-> (post), msg)

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
    `ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

@@ hdl/trpk_pkg.sv @@
// ----------------------------------------------------------------------------
// trpk_pkg
// Constants, coefficient table and command types of the true-peak detector.
// ----------------------------------------------------------------------------
package trpk_pkg;

    localparam int RING_DEPTH_DEF  = 16;
    localparam int TAP_COUNT_DEF   = 12;
    localparam int PHASE_COUNT_DEF = 3;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int MAX_TAPS   = 16;
    localparam int COEF_ROWS  = 8;
    localparam int PHASE_IW   = 3;
    localparam int TAP_IW     = 4;
    localparam int ACC_W      = PROD_W + TAP_IW;
    localparam int FRAC_SHIFT = 15;
    localparam int PEAK_W     = 24;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t COEF_TABLE [COEF_ROWS][MAX_TAPS] = '{
        '{16'sd56, -16'sd423, 16'sd1422, -16'sd3224, 16'sd6498, 16'sd30163,
          -16'sd3224, 16'sd1422, -16'sd423, 16'sd56, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd92, -16'sd688, 16'sd2235, -16'sd5246, 16'sd19992, 16'sd19992,
          -16'sd5246, 16'sd2235, -16'sd688, 16'sd92, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd56, -16'sd423, 16'sd1422, -16'sd3224, 16'sd30163, 16'sd6498,
          -16'sd3224, 16'sd1422, -16'sd423, 16'sd56, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{default: 16'sd0},
        '{default: 16'sd0},
        '{default: 16'sd0},
        '{default: 16'sd0},
        '{default: 16'sd0}
    };

    typedef struct packed {
        logic                load;
        logic                issue;
        logic [PHASE_IW-1:0] phase;
        logic [TAP_IW-1:0]   tap;
        logic                close;
        logic                compare;
        logic                publish;
    } trpk_cmd_t;

    typedef struct packed {
        logic out_full;
    } trpk_status_t;

endpackage

@@ hdl/trpk_datapath.sv @@
// ----------------------------------------------------------------------------
// trpk_datapath
// Sample ring, shared multiply-accumulate, rounding and running-peak logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trpk_datapath #(
    parameter int RING_DEPTH = trpk_pkg::RING_DEPTH_DEF,
    parameter int TAP_COUNT  = trpk_pkg::TAP_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  trpk_pkg::trpk_cmd_t             cmd,
    output trpk_pkg::trpk_status_t          status,
    input  logic [trpk_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [trpk_pkg::PEAK_W-1:0]     peak,
    output logic                            peak_raised
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int SHIFTED_W = trpk_pkg::ACC_W - trpk_pkg::FRAC_SHIFT;

    logic [trpk_pkg::SAMPLE_W-1:0]       ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]               ring_valid_reg;
    logic [ADDR_W-1:0]                   slot_reg;
    logic [ADDR_W-1:0]                   slot_next;
    logic [ADDR_W:0]                     slot_ext;
    logic [ADDR_W:0]                     back_dist;
    logic [ADDR_W-1:0]                   rd_addr;

    logic [trpk_pkg::SAMPLE_W-1:0]       rd_raw_reg;
    logic                                rd_valid_reg;
    logic signed [trpk_pkg::SAMPLE_W-1:0] rd_data;
    trpk_pkg::coef_t                     coef_reg;
    logic                                s1_reg;
    logic signed [trpk_pkg::PROD_W-1:0]  prod_reg;
    logic                                s2_reg;
    logic signed [trpk_pkg::ACC_W-1:0]   acc_reg;

    logic [trpk_pkg::ACC_W-1:0]          acc_mag;
    logic [trpk_pkg::ACC_W-1:0]          acc_round;
    logic [SHIFTED_W-1:0]                acc_shifted;
    logic [trpk_pkg::PEAK_W-1:0]         mag_next;
    logic [trpk_pkg::PEAK_W-1:0]         mag_reg;
    logic [trpk_pkg::PEAK_W-1:0]         raw_mag;

    logic [trpk_pkg::PEAK_W-1:0]         peak_reg;
    logic                                raised_reg;
    logic [trpk_pkg::PEAK_W-1:0]         out_peak_reg;
    logic                                out_raised_reg;
    logic                                out_valid_reg;

    // read address: newest sample minus the tap's distance, wrapped
    always_comb
    begin
        slot_ext  = {1'b0, slot_reg};
        back_dist = (ADDR_W+1)'(TAP_COUNT - 1) - (ADDR_W+1)'(cmd.tap);
        if (slot_ext >= back_dist)
        begin
            rd_addr = ADDR_W'(slot_ext - back_dist);
        end
        else
        begin
            rd_addr = ADDR_W'(slot_ext + (ADDR_W+1)'(RING_DEPTH) - back_dist);
        end
        if (slot_reg == ADDR_W'(RING_DEPTH - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ring_mem[slot_reg] <= sample;
        end
        rd_raw_reg <= ring_mem[rd_addr];
        coef_reg   <= trpk_pkg::COEF_TABLE[cmd.phase][cmd.tap];
        prod_reg   <= rd_data * coef_reg;
        mag_reg    <= mag_next;
    end

    assign rd_data = rd_valid_reg ? $signed(rd_raw_reg) : '0;
    assign raw_mag = sample[trpk_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;

    // magnitude, round half away from zero, saturate
    always_comb
    begin
        acc_mag     = acc_reg[trpk_pkg::ACC_W-1] ? trpk_pkg::ACC_W'(-acc_reg)
                                                 : trpk_pkg::ACC_W'(acc_reg);
        acc_round   = acc_mag + trpk_pkg::ACC_W'(1 << (trpk_pkg::FRAC_SHIFT - 1));
        acc_shifted = acc_round[trpk_pkg::ACC_W-1:trpk_pkg::FRAC_SHIFT];
        if (|acc_shifted[SHIFTED_W-1:trpk_pkg::PEAK_W])
        begin
            mag_next = '1;
        end
        else
        begin
            mag_next = acc_shifted[trpk_pkg::PEAK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
            slot_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            s1_reg         <= 1'b0;
            s2_reg         <= 1'b0;
            acc_reg        <= '0;
            peak_reg       <= '0;
            raised_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_peak_reg   <= '0;
            out_raised_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ring_valid_reg[rd_addr];
            s1_reg       <= cmd.issue;
            s2_reg       <= s1_reg;

            if (cmd.load || cmd.compare)
            begin
                acc_reg <= '0;
            end
            else if (s2_reg)
            begin
                acc_reg <= acc_reg + trpk_pkg::ACC_W'(prod_reg);
            end

            if (cmd.load)
            begin
                ring_valid_reg[slot_reg] <= 1'b1;
                if (raw_mag > peak_reg)
                begin
                    peak_reg   <= raw_mag;
                    raised_reg <= 1'b1;
                end
                else
                begin
                    raised_reg <= 1'b0;
                end
            end
            else if (cmd.compare && (mag_reg > peak_reg))
            begin
                peak_reg   <= mag_reg;
                raised_reg <= 1'b1;
            end

            if (cmd.publish)
            begin
                out_valid_reg  <= 1'b1;
                out_peak_reg   <= peak_reg;
                out_raised_reg <= raised_reg;
                slot_reg       <= slot_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_full = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign peak            = out_peak_reg;
    assign peak_raised     = out_raised_reg;

    `ASSERT_CLK(a_clear_not_during_acc, !(s2_reg && (cmd.load || cmd.compare)),
        "accumulator cleared while a product is pending")
    `ASSERT_NEXT(a_peak_monotonic, 1'b1, peak_reg >= $past(peak_reg),
        "running peak decreased")
    `ASSERT_NEXT(a_publish_sets_valid, cmd.publish,
        m_tvalid && (peak == $past(peak_reg)), "published peak lost")

endmodule

@@ hdl/trpk_ctrl.sv @@
// ----------------------------------------------------------------------------
// trpk_ctrl
// Sequencer that steps the shared MAC over every phase and tap of one request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trpk_ctrl #(
    parameter int TAP_COUNT   = trpk_pkg::TAP_COUNT_DEF,
    parameter int PHASE_COUNT = trpk_pkg::PHASE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  trpk_pkg::trpk_status_t status,
    output trpk_pkg::trpk_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_CLOSE,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [trpk_pkg::PHASE_IW-1:0] phase_reg;
    logic [trpk_pkg::TAP_IW-1:0]   tap_reg;
    logic                          last_tap;
    logic                          last_phase;

    assign last_tap   = (tap_reg == trpk_pkg::TAP_IW'(TAP_COUNT - 1));
    assign last_phase = (phase_reg == trpk_pkg::PHASE_IW'(PHASE_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    phase_reg <= '0;
                    tap_reg   <= '0;
                    if (s_tvalid)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (last_tap)
                    begin
                        state_reg <= ST_DRAIN1;
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                ST_DRAIN1: state_reg <= ST_DRAIN2;
                ST_DRAIN2: state_reg <= ST_CLOSE;
                ST_CLOSE:  state_reg <= ST_CMP;
                ST_CMP:
                begin
                    tap_reg <= '0;
                    if (last_phase)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                ST_DONE:
                begin
                    if (!status.out_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd         = '0;
        cmd.phase   = phase_reg;
        cmd.tap     = tap_reg;
        cmd.load    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.issue   = (state_reg == ST_RUN);
        cmd.close   = (state_reg == ST_CLOSE);
        cmd.compare = (state_reg == ST_CMP);
        cmd.publish = (state_reg == ST_DONE) && !status.out_full;
    end

    `ASSERT_NEXT(a_load_starts_run, cmd.load,
        cmd.issue && (tap_reg == '0) && (phase_reg == '0), "run did not start at tap zero")
    `ASSERT_IMPL(a_publish_free, cmd.publish, !status.out_full,
        "result published over a waiting result")
    `ASSERT_NEXT(a_close_before_cmp, cmd.close, cmd.compare,
        "compare did not follow close")

endmodule

@@ hdl/true_peak_oversampling_detector.sv @@
// ----------------------------------------------------------------------------
// true_peak_oversampling_detector
// True-peak meter: running maximum over raw samples and interpolated phases.
// ----------------------------------------------------------------------------
// Each request carries one signed Q1.23 sample; each result gives the running
// true peak (unsigned Q1.23, saturating) and whether this sample raised it.
// One multiplier is shared by all taps of all phases, so each request is
// stepped through every tap of every phase before the next one is accepted.
// A finished result waits in the output register while the next request is
// worked on. Reset clears the sample history at once through per-entry valid
// bits.
module true_peak_oversampling_detector #(
    parameter int RING_DEPTH  = trpk_pkg::RING_DEPTH_DEF,
    parameter int TAP_COUNT   = trpk_pkg::TAP_COUNT_DEF,
    parameter int PHASE_COUNT = trpk_pkg::PHASE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [23:0] peak, [24] peak_raised, [31:25] zero
);

    trpk_pkg::trpk_cmd_t         cmd;
    trpk_pkg::trpk_status_t      status;
    logic [trpk_pkg::PEAK_W-1:0] peak;
    logic                        peak_raised;

    trpk_ctrl #(
        .TAP_COUNT   (TAP_COUNT),
        .PHASE_COUNT (PHASE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    trpk_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .TAP_COUNT  (TAP_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .peak        (peak),
        .peak_raised (peak_raised)
    );

    assign m_tdata = {7'b0, peak_raised, peak};

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the true-peak oversampling detector. A directed
// table covers reset, the field extremes and ring warm-up. Random bursts of
// loud, noisy, quiet and edge-value samples follow. Every result is checked
// against its typed table row or else a local model of the interpolating
// peak meter, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 6;
    localparam int     GAP_MAX      = 18;
    localparam int     RANDOM_ITEMS = 800;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     HIST_DEPTH   = 16;
    localparam int     FIR_TAPS     = 12;
    localparam int     FIR_PHASES   = 3;
    localparam int     ROUND_SHIFT  = 15;
    localparam longint ROUND_HALF   = 64'sd16384;
    localparam longint PEAK_MAX     = 64'sd16777215;
    localparam int     DIR_ROWS     = 18;

    localparam int FIR_COEF [FIR_PHASES][FIR_TAPS] = '{
        '{56, -423, 1422, -3224, 6498, 30163, -3224, 1422, -423, 56, 0, 0},
        '{92, -688, 2235, -5246, 19992, 19992, -5246, 2235, -688, 92, 0, 0},
        '{56, -423, 1422, -3224, 30163, 6498, -3224, 1422, -423, 56, 0, 0}
    };

    typedef enum int {
        BURST_LOUD,
        BURST_NOISE,
        BURST_QUIET,
        BURST_EDGE
    } burst_kind_t;

    typedef struct packed {
        logic [23:0] peak;
        logic        raised;
    } peak_rpt_t;

    typedef struct packed {
        logic [23:0] smp;
        logic        typed;
        logic [23:0] peak;
        logic        raised;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{24'h000000, 1'b1, 24'h000000, 1'b0},
        '{24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b1},
        '{24'h800000, 1'b1, 24'h800000, 1'b1},
        '{24'h000000, 1'b1, 24'h800000, 1'b0},
        '{24'h000000, 1'b0, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, 24'h000000, 1'b0},
        '{24'h000001, 1'b0, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
        '{24'hAAAAAA, 1'b0, 24'h000000, 1'b0},
        '{24'h555555, 1'b0, 24'h000000, 1'b0},
        '{24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
        '{24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
        '{24'h800000, 1'b0, 24'h000000, 1'b0},
        '{24'h800000, 1'b0, 24'h000000, 1'b0},
        '{24'h7FFFFF, 1'b0, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, 24'h000000, 1'b0},
        '{24'h400000, 1'b0, 24'h000000, 1'b0},
        '{24'hC00000, 1'b0, 24'h000000, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    logic signed [23:0] hist [HIST_DEPTH];
    logic [3:0]         hist_slot;
    logic [23:0]        peak_model;

    peak_rpt_t pending_q [$];
    int        err_count;
    int        n_sent;
    int        n_checked;
    int        n_raised;
    bit        tx_calm;

    true_peak_oversampling_detector u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic peak_rpt_t advance_peak_model(input logic [23:0] smp);
        peak_rpt_t   rpt;
        logic [23:0] prior;
        longint      acc;
        longint      mag;
        logic [3:0]  idx;
        prior = peak_model;
        hist[hist_slot] = smp;
        mag = smp[23] ? -longint'($signed(smp)) : longint'($signed(smp));
        if (mag > longint'(peak_model))
            peak_model = mag[23:0];
        for (int p = 0; p < FIR_PHASES; p++)
        begin
            acc = 0;
            for (int k = 0; k < FIR_TAPS; k++)
            begin
                idx = hist_slot - 4'(FIR_TAPS - 1 - k);
                acc += longint'(hist[idx]) * longint'(FIR_COEF[p][k]);
            end
            mag = (acc < 0) ? -acc : acc;
            mag = (mag + ROUND_HALF) >>> ROUND_SHIFT;
            if (mag > PEAK_MAX)
                mag = PEAK_MAX;
            if (mag > longint'(peak_model))
                peak_model = mag[23:0];
        end
        hist_slot = hist_slot + 4'd1;
        rpt.peak = peak_model;
        rpt.raised = (peak_model > prior);
        return rpt;
    endfunction

    function automatic logic [23:0] draw_sample(input burst_kind_t kind);
        int mag;
        case (kind)
            BURST_LOUD:
            begin
                if ($urandom_range(0, 15) == 0)
                    return 24'h800000;
                mag = $urandom_range(7000000, 8388607);
                return $urandom_range(0, 1) ? 24'(-mag) : 24'(mag);
            end
            BURST_NOISE:
                return 24'($urandom());
            BURST_QUIET:
                return 24'($signed($urandom_range(0, 8192)) - 4096);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return 24'h000000;
                    1:       return 24'h000001;
                    2:       return 24'hFFFFFF;
                    3:       return 24'h7FFFFF;
                    default: return 24'h800000;
                endcase
            end
        endcase
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // hold the request until accepted; entered and left at a falling edge
    task automatic push_sample(input logic [23:0] smp, input int gap, input bit typed,
                               input peak_rpt_t typed_rpt);
        peak_rpt_t rpt;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge clk); while (!s_tready);
        rpt = advance_peak_model(smp);
        pending_q.insert(pending_q.size(), typed ? typed_rpt : rpt);
        n_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        burst_kind_t kind;
        int          burst_left;
        int          pick;
        bit          drained;
        peak_rpt_t   row_rpt;
        s_tvalid   = 1'b0;
        s_tdata    = 24'h0;
        rst_n      = 1'b0;
        err_count  = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_raised   = 0;
        tx_calm    = 1'b0;
        hist_slot  = 4'd0;
        peak_model = 24'h0;
        burst_left = 0;
        drained    = 1'b0;
        kind       = BURST_NOISE;
        foreach (hist[i])
            hist[i] = 24'sh0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row_rpt.peak   = DIR_TABLE[i].peak;
            row_rpt.raised = DIR_TABLE[i].raised;
            push_sample(DIR_TABLE[i].smp, draw_gap(tx_calm), DIR_TABLE[i].typed, row_rpt);
        end

        row_rpt = '0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (burst_left == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    kind = BURST_LOUD;
                else if (pick < 7)
                    kind = BURST_NOISE;
                else if (pick < 9)
                    kind = BURST_QUIET;
                else
                    kind = BURST_EDGE;
                burst_left = $urandom_range(4, 40);
                tx_calm = ($urandom_range(0, 4) == 0);
            end
            burst_left--;
            // drain everything once mid-run
            if (!drained && i == RANDOM_ITEMS / 2)
            begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                do @(negedge clk); while (pending_q.size() != 0);
            end
            push_sample(draw_sample(kind), draw_gap(tx_calm), 1'b0, row_rpt);
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_q.size() != 0)
        begin
            $error("%0d results never arrived", pending_q.size());
            err_count++;
        end

        $display("Sent %0d samples (directed extremes and warm-up, random bursts), checked %0d",
                 n_sent, n_checked);
        $display("Peak rose %0d times, final peak %0d, errors %0d",
                 n_raised, peak_model, err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        peak_rpt_t exp_rpt;
        int        gap;
        bit        rx_calm;
        int        stretch_left;
        m_tready     = 1'b0;
        rx_calm      = 1'b0;
        stretch_left = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (stretch_left == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
                stretch_left = $urandom_range(10, 60);
            end
            stretch_left--;
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: peak %0d raised %0b", m_tdata[23:0], m_tdata[24]);
                err_count++;
            end
            else
            begin
                exp_rpt = pending_q.pop_front();
                n_checked++;
                if (exp_rpt.raised)
                    n_raised++;
                if (m_tdata[23:0] !== exp_rpt.peak)
                begin
                    $error("peak: expected %0d, actual %0d", exp_rpt.peak, m_tdata[23:0]);
                    err_count++;
                end
                if (m_tdata[24] !== exp_rpt.raised)
                begin
                    $error("peak_raised: expected %0b, actual %0b", exp_rpt.raised,
                           m_tdata[24]);
                    err_count++;
                end
            end
            @(negedge clk);
        end
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/trpk_pkg.sv
hdl/trpk_datapath.sv
hdl/trpk_ctrl.sv
hdl/true_peak_oversampling_detector.sv
tb/tb_top.sv
